>>> rtl/core/lap_pkg.sv
`default_nettype none

package lap_pkg;

  parameter int unsigned SizeW  = 24;
  parameter int unsigned ASizeW = 25;
  parameter int unsigned OffW   = 31;
  parameter int unsigned CandW  = 32;
  parameter int unsigned EvW    = 8;
  parameter int unsigned AliasW = 8;

  parameter logic [AliasW-1:0] NoAlias = 8'hFF;

  typedef struct packed {
    logic              start_plan;
    logic              last_in_plan;
    logic [SizeW-1:0]  size_bytes;
    logic [EvW-1:0]    first_event;
    logic [EvW-1:0]    last_event;
    logic [AliasW-1:0] alias_index;
  } in_item_t;

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic [OffW-1:0] arena_size;
    logic            plan_done;
    logic            overflow;
  } out_item_t;

  typedef struct packed {
    logic [OffW-1:0]   offset;
    logic [ASizeW-1:0] aligned_size;
    logic [EvW-1:0]    first;
    logic [EvW-1:0]    last;
    logic              is_alias;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DISP  = 6'b000010,
    S_ALIAS = 6'b000100,
    S_ROUND = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

>>> rtl/core/lap_stream_if.sv
`default_nettype none

interface lap_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lap_round.sv
`default_nettype none

module lap_round
  import lap_pkg::*;
#(
  parameter int unsigned ALIGN_BYTES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SizeW-1:0]  size_i,
  output logic                   done_o,
  output logic [ASizeW-1:0]      asize_o
);

  localparam bit AlignPow2 = ((ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0);

  logic              done_q;
  logic [ASizeW-1:0] asize_q;

  if (AlignPow2) begin : g_pow2
    localparam logic [ASizeW-1:0] Mask = ASizeW'(ALIGN_BYTES - 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        asize_q <= (ASizeW'(size_i) + Mask) & ~Mask;
      end
    end
  end else begin : g_recip
    localparam int unsigned ShiftW = ASizeW + $clog2(ALIGN_BYTES);
    localparam int unsigned RcpW   = ASizeW + 2;
    localparam int unsigned ProdW  = ASizeW + RcpW;
    localparam logic [63:0] Recip64 =
      ((64'd1 << ShiftW) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [RcpW-1:0]   Recip  = RcpW'(Recip64);
    localparam logic [ASizeW-1:0] AlignA = ASizeW'(ALIGN_BYTES);
    localparam logic [ASizeW-1:0] Bias   = ASizeW'(ALIGN_BYTES - 1);

    logic              quot_vld_q;
    logic [ASizeW-1:0] quot_q;
    logic [ASizeW-1:0] biased;
    logic [ProdW-1:0]  prod;

    // divide the biased size by a scaled reciprocal, exact over the size range
    assign biased = ASizeW'(size_i) + Bias;
    assign prod   = ProdW'(biased) * ProdW'(Recip);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        quot_vld_q <= 1'b0;
        done_q     <= 1'b0;
      end else begin
        quot_vld_q <= start_i;
        done_q     <= quot_vld_q;
      end
    end

    // register the quotient, then scale it back up into the aligned size
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        quot_q <= ASizeW'(prod >> ShiftW);
      end
      if (quot_vld_q) begin
        asize_q <= quot_q * AlignA;
      end
    end
  end

  assign done_o  = done_q;
  assign asize_o = asize_q;

endmodule

`default_nettype wire

>>> rtl/core/lifetime_aware_offset_planner_core.sv
// Places buffers in an arena one at a time: each item carries a size, a live
// interval and an optional alias, and gets back its byte offset, the running
// arena end, an echo of the end-of-plan flag and an overflow flag when the
// entry store already holds MAX_BUFFERS buffers. Entries live in one memory
// with a single registered read port; a non-aliased buffer is placed by
// scanning the stored entries through that port, one per cycle, and the scan
// restarts from the first entry after every collision. Size rounding goes
// through a scaled reciprocal when ALIGN_BYTES is not a power of two.
// Completion waits while the output still holds a result that has not been
// taken. The next item is taken while the previous result waits at the
// output.
`default_nettype none

module lifetime_aware_offset_planner_core
  import lap_pkg::*;
#(
  parameter int unsigned MAX_BUFFERS = 64,
  parameter int unsigned ALIGN_BYTES = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lap_stream_if.sink   req_i,
  lap_stream_if.source res_o
);

  localparam int unsigned CntW = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned IdxW = $clog2(MAX_BUFFERS);
  localparam int unsigned CmpW = (CntW > AliasW) ? CntW : AliasW;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [OffW-1:0]   arena_q, arena_d;
  in_item_t          item_q, item_d;
  logic [ASizeW-1:0] sz_q, sz_d;
  logic [CandW-1:0]  cand_q, cand_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [OffW-1:0]   res_off_q, res_off_d;
  logic [OffW-1:0]   res_end_q, res_end_d;
  logic              res_ovf_q, res_ovf_d;
  out_item_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  entry_t            mem [MAX_BUFFERS];
  entry_t            rd_data_q;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  entry_t            wr_data;

  logic              round_start;
  logic              round_done;
  logic [ASizeW-1:0] round_asize;

  logic              is_alias;
  logic              overlap;
  logic [CandW-1:0]  ent_end;
  logic [CandW:0]    cand_end;
  logic              hit;
  logic              scan_done;
  logic              out_free;
  logic [OffW-1:0]   arena_new;

  lap_round #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(round_start),
    .size_i (item_q.size_bytes),
    .done_o (round_done),
    .asize_o(round_asize)
  );

  assign is_alias  = (item_q.alias_index != NoAlias);
  assign overlap   = !((item_q.last_event < rd_data_q.first) ||
                       (rd_data_q.last < item_q.first_event));
  assign ent_end   = CandW'(rd_data_q.offset) + CandW'(rd_data_q.aligned_size);
  assign cand_end  = {1'b0, cand_q} + (CandW + 1)'(sz_q);
  assign hit       = chk_vld_q && !rd_data_q.is_alias && overlap &&
                     (cand_q < ent_end) &&
                     (cand_end > (CandW + 1)'(rd_data_q.offset));
  assign scan_done = !chk_vld_q && (rd_idx_q >= count_q);
  assign out_free  = !out_vld_q || res_o.ready;
  assign arena_new = (!res_ovf_q && !is_alias && (res_end_q > arena_q)) ? res_end_q
                                                                      : arena_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    arena_d     = arena_q;
    item_d      = item_q;
    sz_d        = sz_q;
    cand_d      = cand_q;
    rd_idx_d    = rd_idx_q;
    chk_vld_d   = chk_vld_q;
    res_off_d   = res_off_q;
    res_end_d   = res_end_q;
    res_ovf_d   = res_ovf_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !res_o.ready;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_data     = '0;
    round_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          item_d  = req_i.payload;
          state_d = S_DISP;
          if (req_i.payload.start_plan) begin
            count_d = '0;
            arena_d = '0;
          end
        end
      end
      S_DISP: begin
        res_ovf_d = 1'b0;
        res_off_d = '0;
        if (count_q >= CntW'(MAX_BUFFERS)) begin
          res_ovf_d = 1'b1;
          state_d   = S_DONE;
        end else if (is_alias) begin
          if (CmpW'(item_q.alias_index) < CmpW'(count_q)) begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(item_q.alias_index);
            state_d = S_ALIAS;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          round_start = 1'b1;
          state_d     = S_ROUND;
        end
      end
      S_ALIAS: begin
        res_off_d = rd_data_q.offset;
        state_d   = S_DONE;
      end
      S_ROUND: begin
        if (round_done) begin
          sz_d      = round_asize;
          cand_d    = '0;
          rd_idx_d  = '0;
          chk_vld_d = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          // bump past the colliding entry and restart, dropping the read in flight
          cand_d    = ent_end;
          rd_idx_d  = '0;
          chk_vld_d = 1'b0;
        end else if (scan_done) begin
          res_off_d = cand_q[CandW-1] ? {OffW{1'b1}} : cand_q[OffW-1:0];
          res_end_d = (|cand_end[CandW:OffW]) ? {OffW{1'b1}} : cand_end[OffW-1:0];
          state_d   = S_DONE;
        end else if (rd_idx_q < count_q) begin
          rd_en     = 1'b1;
          rd_addr   = rd_idx_q[IdxW-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
          chk_vld_d = 1'b1;
        end else begin
          chk_vld_d = 1'b0;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_d.offset     = res_off_q;
          out_d.arena_size = arena_new;
          out_d.plan_done  = item_q.last_in_plan;
          out_d.overflow   = res_ovf_q;
          out_vld_d        = 1'b1;
          arena_d          = arena_new;
          if (!res_ovf_q) begin
            wr_en                = 1'b1;
            wr_data.offset       = res_off_q;
            wr_data.aligned_size = is_alias ? '0 : sz_q;
            wr_data.first        = item_q.first_event;
            wr_data.last         = item_q.last_event;
            wr_data.is_alias     = is_alias;
            count_d              = count_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      arena_q   <= '0;
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      arena_q   <= arena_d;
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    sz_q      <= sz_d;
    cand_q    <= cand_d;
    res_off_q <= res_off_d;
    res_end_q <= res_end_d;
    res_ovf_q <= res_ovf_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IdxW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = out_vld_q;
  assign res_o.payload = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_BUFFERS))
    else $error("entry count beyond store depth");

  a_scan_read_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && state_q == S_SCAN) |-> (rd_idx_q < count_q))
    else $error("scan read of an entry not yet stored");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside completion");

  a_cand_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q == S_SCAN)) |-> (cand_q >= $past(cand_q)))
    else $error("candidate offset moved backwards during scan");

endmodule

`default_nettype wire
